/* design/lru_frame_replacer_unit_macros.svh */
// -----------------------------------------------------------------------------
// LRU frame replacer assertion macros
// Shared property forms for the checks at the end of the top level.
// -----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_UNIT_MACROS_SVH
`define LRU_FRAME_REPLACER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfr check failed");

// Next-cycle implication, disabled while reset is high.
`define LFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfr check failed");

`endif

/* design/lfr_pkg.sv */
// -----------------------------------------------------------------------------
// LRU frame replacer package
// Payload types, operation codes, controller states and the command and status
// groups between the controller and the datapath.
// -----------------------------------------------------------------------------
package lfr_pkg;

   localparam int FRAME_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int FRAME_SPAN = 2 ** FRAME_W;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_VICTIM = 2'd0,
      OP_PIN    = 2'd1,
      OP_UNPIN  = 2'd2
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [FRAME_W-1:0] frame;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [FRAME_W-1:0] victim_frame;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_UNLINK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic unlink;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic do_unpin;
      logic do_unlink;
      logic rsp_free;
   } ctrl_status_type;

endpackage

/* design/lfr_controller.sv */
// -----------------------------------------------------------------------------
// LRU frame replacer controller
// Sequences one item through decode, a list unlink where a frame is removed, and result hand-off.
// -----------------------------------------------------------------------------
module lfr_controller
   import lfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.do_unlink ? ST_UNLINK : ST_FINISH;
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/lfr_datapath.sv */
// -----------------------------------------------------------------------------
// LRU frame replacer datapath
// Presence bits, list ends, count, the two link memories and the result
// register.
// -----------------------------------------------------------------------------
module lfr_datapath
   import lfr_pkg::*;
#(
   parameter int NUM_FRAMES = 64
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [COUNT_W-1:0] csr_data,
   input  req_type            req_data,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   // Only frames that the frame field can name need storage.
   localparam int DEPTH = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [FRAME_W:0] DEPTH_V = (FRAME_W + 1)'(DEPTH);

   op_type             op_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [COUNT_W-1:0] capacity_ff;
   logic [COUNT_W-1:0] held_ff;
   logic [AW-1:0]      newest_ff;
   logic [AW-1:0]      oldest_ff;
   logic [DEPTH-1:0]   present_ff;
   logic [AW-1:0]      target_ff;
   logic [AW-1:0]      rd_next_ff;
   logic [AW-1:0]      rd_prev_ff;
   logic               found_ff;
   logic [FRAME_W-1:0] victim_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [AW-1:0] next_mem [DEPTH];
   logic [AW-1:0] prev_mem [DEPTH];

   logic          in_range;
   logic [AW-1:0] frame_idx;
   logic          frame_present;
   logic          held_zero;
   logic          held_many;
   logic          victim_hit;
   logic [AW-1:0] exec_addr;
   logic          next_we;
   logic [AW-1:0] next_wa;
   logic [AW-1:0] next_wd;
   logic          prev_we;
   logic [AW-1:0] prev_wa;
   logic [AW-1:0] prev_wd;

   // Decode of the held item against the current set.
   assign in_range      = {1'b0, frame_ff} < DEPTH_V;
   assign frame_idx     = frame_ff[AW-1:0];
   assign frame_present = in_range ? present_ff[frame_idx] : 1'b0;
   assign held_zero     = (held_ff == '0);
   assign held_many     = (held_ff > COUNT_W'(1));
   assign victim_hit    = (op_ff == OP_VICTIM) && !held_zero;
   assign exec_addr     = (op_ff == OP_VICTIM) ? oldest_ff : frame_idx;

   always_comb begin
      status.do_unpin  = 1'b0;
      status.do_unlink = 1'b0;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
      case (op_ff)
         OP_VICTIM: status.do_unlink = !held_zero;
         OP_PIN:    status.do_unlink = frame_present;
         OP_UNPIN:  status.do_unpin  = in_range && !frame_present && (held_ff < capacity_ff);
         default:   status.do_unlink = 1'b0;
      endcase
   end

   // Link memory writes: a push at the newest end, or bridging the gap an
   // unlinked frame leaves behind.
   always_comb begin
      next_we = 1'b0;
      next_wa = frame_idx;
      next_wd = newest_ff;
      prev_we = 1'b0;
      prev_wa = newest_ff;
      prev_wd = frame_idx;
      if (cmd.exec && status.do_unpin) begin
         next_we = !held_zero;
         prev_we = !held_zero;
      end else if (cmd.unlink && held_many) begin
         next_we = (target_ff != newest_ff);
         next_wa = rd_prev_ff;
         next_wd = rd_next_ff;
         prev_we = (target_ff != oldest_ff);
         prev_wa = rd_next_ff;
         prev_wd = rd_prev_ff;
      end
   end

   // Link memories with registered reads of the frame being removed.
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      rd_next_ff <= next_mem[exec_addr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      rd_prev_ff <= prev_mem[exec_addr];
   end

   // Set state, capacity and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         held_ff      <= '0;
         newest_ff    <= '0;
         oldest_ff    <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            capacity_ff <= csr_data;
         end
         if (cmd.exec && status.do_unpin) begin
            if (held_zero) begin
               oldest_ff <= frame_idx;
            end
            newest_ff             <= frame_idx;
            present_ff[frame_idx] <= 1'b1;
            held_ff               <= held_ff + COUNT_W'(1);
         end
         if (cmd.unlink) begin
            present_ff[target_ff] <= 1'b0;
            if (!held_many) begin
               held_ff   <= '0;
               newest_ff <= '0;
               oldest_ff <= '0;
            end else begin
               if (target_ff == newest_ff) begin
                  newest_ff <= rd_next_ff;
               end
               if (target_ff == oldest_ff) begin
                  oldest_ff <= rd_prev_ff;
               end
               held_ff <= held_ff - COUNT_W'(1);
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item capture, victim selection and result payload.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_data.operation;
         frame_ff <= req_data.frame;
      end
      if (cmd.exec) begin
         target_ff <= exec_addr;
         found_ff  <= victim_hit;
         victim_ff <= victim_hit ? FRAME_W'(oldest_ff) : '0;
      end
      if (cmd.finish) begin
         rsp_data_ff.found        <= found_ff;
         rsp_data_ff.victim_frame <= victim_ff;
         rsp_data_ff.count        <= held_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/lru_frame_replacer_unit.sv */
// -----------------------------------------------------------------------------
// LRU frame replacer unit
// Keeps the evictable frames of a buffer pool as a doubly linked list, newest
// first, and serves victim, pin and unpin requests against it.
// -----------------------------------------------------------------------------
//  Channel  Dir  Ports                               Carries
//  req      in   req_valid, req_ready, req_data      operation and frame
//  rsp      out  rsp_valid, rsp_ready, rsp_data      found, victim_frame, count
//  csr      in   csr_valid, csr_ready, csr_data      capacity
//
//  An item passes from acceptance through decode to the result hand-off (unpin,
//  misses, unknown codes); victim and pin that remove a frame add an unlink
//  step, which the registered read port of the link memories requires.
//  One item is in work at a time; a new one is taken while the last result
//  still waits, and its result is held back until rsp_ready frees the slot.
//  Reset is synchronous and clears the set at once; capacity returns to 64.
//  The capacity register takes a write in any cycle.
// -----------------------------------------------------------------------------
`include "lru_frame_replacer_unit_macros.svh"

module lru_frame_replacer_unit
   import lfr_pkg::*;
#(
   parameter int NUM_FRAMES = 64
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // The capacity register never stalls a write.
   assign csr_ready = 1'b1;

   // Sequencer.
   lfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // List storage and result register.
   lfr_datapath #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An accepted item is decoded in the very next cycle.
   `LFR_ASSERT_NEXT(a_exec_follows_accept, clock, reset, req_valid && req_ready, cmd.exec)

   // Acceptance and the work steps never overlap.
   `LFR_ASSERT_IMPLY(a_one_step, clock, reset, 1'b1, $onehot0({req_ready, cmd.exec, cmd.unlink, cmd.finish}))

   // A result without a victim carries frame zero.
   `LFR_ASSERT_IMPLY(a_no_victim_zero, clock, reset, rsp_valid && !rsp_data.found, rsp_data.victim_frame == '0)

   // A result is only loaded once the output slot is free.
   `LFR_ASSERT_IMPLY(a_finish_slot_free, clock, reset, cmd.finish, !rsp_valid || rsp_ready)

endmodule

/* tb/tb_lru_frame_replacer_unit.sv */
// -----------------------------------------------------------------------------
// LRU frame replacer unit testbench
// Sends victim, pin, unpin and unknown-code items with random gaps and result back-pressure.
// A predictor keeps the evictable set as an ordered queue, newest first, and
// every returned result is compared field by field with the oldest expected
// one. The capacity register is rewritten between phases, extremes included.
// -----------------------------------------------------------------------------
module tb_lru_frame_replacer_unit
   import lfr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The operation code that the block does not know.
   localparam logic [1:0] OP_UNKNOWN_CODE = 2'd3;
   localparam int RANDOM_ITEMS    = 1400;
   localparam int PRINT_LIMIT     = 50;

   // Predictor of the evictable set and store of the expected results.
   class frame_lru_scoreboard;
      logic [FRAME_W-1:0] lru_order[$];   // index 0 is the most recent frame
      logic [COUNT_W-1:0] capacity;
      rsp_type            expected_rsps[$];
      int                 errors;

      function new();
         capacity = CAPACITY_RESET;
         errors   = 0;
      endfunction

      function void set_capacity(logic [COUNT_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      function int find_frame(logic [FRAME_W-1:0] frame);
         foreach (lru_order[i])
            if (lru_order[i] == frame)
               return i;
         return -1;
      endfunction

      // Applies one accepted item to the set and stores the result it causes.
      function void note_request(req_type item);
         rsp_type expected;
         int      pos;
         expected = '0;
         pos      = find_frame(item.frame);
         case (item.operation)
            OP_VICTIM: begin
               if (lru_order.size() != 0) begin
                  expected.found        = 1'b1;
                  expected.victim_frame = lru_order[lru_order.size() - 1];
                  lru_order.delete(lru_order.size() - 1);
               end
            end
            OP_PIN: begin
               if (pos >= 0)
                  lru_order.delete(pos);
            end
            OP_UNPIN: begin
               if (pos < 0 && lru_order.size() < int'(capacity))
                  lru_order.insert(0, item.frame);
            end
            default: ;
         endcase
         expected.count = COUNT_W'(lru_order.size());
         expected_rsps.push_back(expected);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("%0t: %s", $time, what);
      endtask

      // Compares one accepted result with the oldest expectation.
      task check_response(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch("result arrived with no item outstanding");
         end else begin
            want = expected_rsps.pop_front();
            if (got.found !== want.found)
               report_mismatch($sformatf("found: expected %0d, got %0d",
                                         want.found, got.found));
            if (got.victim_frame !== want.victim_frame)
               report_mismatch($sformatf("victim_frame: expected %0d, got %0d",
                                         want.victim_frame, got.victim_frame));
            if (got.count !== want.count)
               report_mismatch($sformatf("count: expected %0d, got %0d",
                                         want.count, got.count));
         end
      endtask
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data  = '0;

   frame_lru_scoreboard board;
   bit                  req_calm = 1'b0;

   lru_frame_replacer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 25);
   endfunction

   // Watch both channels at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_data);
         if (req_valid && req_ready)
            board.note_request(req_data);
      end
   end

   // Result side: random stalls, with calm stretches between them.
   initial begin : result_drain
      int stall;
      int calm_left;
      bit calm;
      calm_left = 0;
      calm      = 1'b0;
      forever begin
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(5, 60);
         end
         calm_left--;
         stall = calm ? 0 : pick_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // Presents one item and holds it until it is accepted.
   task automatic send_item(input logic [1:0] code, input logic [FRAME_W-1:0] frame);
      req_type item;
      int      gap;
      item.operation = op_type'(code);
      item.frame     = frame;
      gap = req_calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_capacity(input logic [COUNT_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_capacity(value);
   endtask

   // Main stimulus.
   initial begin : stimulus
      logic [FRAME_W-1:0] pool[$];
      logic [FRAME_W-1:0] swap;
      logic [COUNT_W-1:0] cap;
      int done_ops;
      int phase;
      int pool_size;
      int pool_base;
      int burst;
      int unpin_weight;
      int victim_weight;
      int r;
      int j;
      logic [1:0] code;

      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset capacity.
      send_item(OP_VICTIM, 6'd63);        // victim on an empty set
      send_item(OP_PIN, 6'd5);            // pin of an absent frame
      send_item(OP_UNPIN, 6'd0);
      send_item(OP_UNPIN, 6'd63);
      send_item(OP_UNPIN, 6'd0);          // already in the set
      send_item(OP_UNKNOWN_CODE, 6'd63);  // unknown operation
      send_item(OP_PIN, 6'd63);           // removes the newest frame
      send_item(OP_UNPIN, 6'd21);
      send_item(OP_UNPIN, 6'd42);
      send_item(OP_PIN, 6'd21);           // removes a frame from the middle
      send_item(OP_VICTIM, 6'd0);
      send_item(OP_VICTIM, 6'd0);
      send_item(OP_PIN, 6'd42);
      send_item(OP_VICTIM, 6'd42);

      // Small capacity, then capacity lowered below the count.
      write_capacity(7'd2);
      send_item(OP_UNPIN, 6'd1);
      send_item(OP_UNPIN, 6'd2);
      send_item(OP_UNPIN, 6'd3);          // set is full
      write_capacity(7'd1);
      send_item(OP_UNPIN, 6'd4);
      send_item(OP_VICTIM, 6'd0);
      send_item(OP_VICTIM, 6'd0);
      send_item(OP_UNPIN, 6'd7);
      send_item(OP_PIN, 6'd7);            // removes the only frame
      write_capacity(7'd0);
      send_item(OP_UNPIN, 6'd5);
      send_item(OP_VICTIM, 6'd0);

      // Random phases, each with its own capacity, frame pool and mix.
      done_ops = 0;
      phase    = 0;
      while (done_ops < RANDOM_ITEMS) begin
         r = $urandom_range(0, 7);
         case (r)
            0:       cap = 7'd0;
            1:       cap = 7'd1;
            2:       cap = 7'd64;
            3:       cap = 7'd63;
            4:       cap = 7'd2;
            default: cap = COUNT_W'($urandom_range(0, 64));
         endcase
         pool_size = ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(2, 40);
         pool_base = $urandom_range(0, 63);
         if (phase == 0) begin
            cap       = 7'd64;
            pool_size = 64;
         end
         write_capacity(cap);
         req_calm = ($urandom_range(0, 3) == 0);

         // Pool of distinct frames in random order.
         pool.delete();
         for (int i = 0; i < pool_size; i++)
            pool.push_back(FRAME_W'(pool_base + i));
         for (int i = pool_size - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            swap    = pool[i];
            pool[i] = pool[j];
            pool[j] = swap;
         end

         // Fill the set from the pool, sometimes right up to the capacity.
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            foreach (pool[i]) begin
               send_item(OP_UNPIN, pool[i]);
               done_ops++;
            end
         end

         unpin_weight  = $urandom_range(25, 70);
         victim_weight = $urandom_range(10, 45);
         burst = $urandom_range(60, 140);
         for (int i = 0; i < burst; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               code = OP_UNKNOWN_CODE;
            else if (r < 3 + unpin_weight)
               code = OP_UNPIN;
            else if (r < 3 + unpin_weight + victim_weight)
               code = OP_VICTIM;
            else
               code = OP_PIN;
            if (code == OP_VICTIM && $urandom_range(0, 1) == 0)
               send_item(code, FRAME_W'($urandom_range(0, 63)));
            else
               send_item(code, pool[$urandom_range(0, pool_size - 1)]);
            if (code != OP_UNKNOWN_CODE)
               done_ops++;
         end

         // Sometimes drain the set completely by victims.
         if ($urandom_range(0, 2) == 0) begin
            for (int i = 0; i < 66; i++) begin
               send_item(OP_VICTIM, FRAME_W'($urandom_range(0, 63)));
               done_ops++;
            end
         end
         phase++;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Overall time limit.
   initial begin : watchdog
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* lru_frame_replacer_unit.f */
+incdir+design
design/lfr_pkg.sv
design/lfr_controller.sv
design/lfr_datapath.sv
design/lru_frame_replacer_unit.sv
tb/tb_lru_frame_replacer_unit.sv
